### src/lzd_pkg.sv
package lzd_pkg;

  typedef enum logic [7:0] {
    PH_TOKEN    = 8'b0000_0001,
    PH_LITEXT   = 8'b0000_0010,
    PH_LITERAL  = 8'b0000_0100,
    PH_OFFLO    = 8'b0000_1000,
    PH_OFFHI    = 8'b0001_0000,
    PH_MATCHEXT = 8'b0010_0000,
    PH_COPY     = 8'b0100_0000,
    PH_DONE     = 8'b1000_0000
  } phase_t;

  localparam int HISTORY_DEPTH = 65536;

  localparam logic [1:0] MODE_FEED   = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_START  = 2'd2;
  localparam logic [1:0] MODE_IGNORE = 2'd3;

  localparam logic [2:0] REG_ULEN = 3'd0;
  localparam logic [2:0] REG_CLEN = 3'd1;
  localparam logic [2:0] REG_PLEN = 3'd2;
  localparam logic [2:0] REG_OCAP = 3'd3;
  localparam logic [2:0] REG_RAW  = 3'd4;

  localparam logic [2:0] ST_RUN     = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EXHAUST = 3'd2;
  localparam logic [2:0] ST_ZOFF    = 3'd3;
  localparam logic [2:0] ST_CAP     = 3'd4;
  localparam logic [2:0] ST_TRUNC   = 3'd5;

  localparam logic [3:0] NIB_EXT   = 4'hF;
  localparam logic [7:0] BYTE_EXT  = 8'hFF;
  localparam logic [4:0] MATCH_MIN = 5'd4;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data;
  } word_t;

endpackage

### src/lzd_queue.sv
module lzd_queue
  import lzd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_stall,
  input  word_t wr_word,
  output logic  rd_valid,
  input  logic  rd_take,
  output word_t rd_word
);
  word_t      slot [2];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       push;
  logic       pop;

  assign wr_stall = count[1];
  assign rd_valid = count != 2'd0;
  assign rd_word  = slot[rd_ptr];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && rd_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= wr_word;
  end
endmodule

### src/lzd_core.sv
module lzd_core
  import lzd_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_take,
  input  word_t       in_word,
  input  logic [31:0] ulen,
  input  logic [31:0] clen,
  input  logic [31:0] plen,
  input  logic [31:0] ocap,
  input  logic        raw,
  output logic        o_valid,
  input  logic        o_stall,
  output logic        accepted,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        copy_pending,
  output logic        finished,
  output logic [2:0]  end_status,
  output logic        success,
  output logic [31:0] bytes_written,
  output logic [31:0] bytes_consumed
);
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  logic [7:0] history [HISTORY_DEPTH];

  phase_t                 phase;
  logic [31:0]            lit_rem, match_rem;
  logic [3:0]             base;
  logic [15:0]            offset;
  logic                   zfill, chunk_raw, ok;
  logic [COUNT_WIDTH-1:0] ocnt, icnt;
  logic [2:0]             status;

  // pipeline stage: history read is registered; byte is resolved in stage 2
  logic                   s_valid;
  logic                   s_accepted, s_ovalid, s_hist, s_fwd;
  logic [7:0]             s_byte, s_rd;
  phase_t                 s_phase;
  logic [2:0]             s_status;
  logic                   s_ok;
  logic [31:0]            s_ocnt, s_icnt;
  logic [7:0]             last_byte;

  // result register
  logic                   r_valid;

  logic adv_ok;
  assign adv_ok = !r_valid || !o_stall || !s_valid;
  assign in_take = in_valid && (!s_valid || !r_valid || !o_stall);

  // next-state computation; the phase settle is resolved as a short chain over phases
  phase_t                 ph_n;
  logic [31:0]            lit_n, mat_n;
  logic [3:0]             base_n;
  logic [15:0]            off_n;
  logic                   zf_n, raw_n, ok_n;
  logic [COUNT_WIDTH-1:0] oc_n, ic_n;
  logic [2:0]             st_n;
  logic                   acc_n, ov_n, hist_n, fwd_n;
  logic [7:0]             ob_n;
  logic [15:0]            rd_addr;
  logic                   oempty;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [7:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {25'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  logic cmp_o_ge, cmp_i_ge, cmp_i_lt2;

  always_comb begin
    ph_n = phase; lit_n = lit_rem; mat_n = match_rem; base_n = base; off_n = offset;
    zf_n = zfill; raw_n = chunk_raw; ok_n = ok; oc_n = ocnt; ic_n = icnt; st_n = status;
    acc_n = 1'b0; ov_n = 1'b0; hist_n = 1'b0; fwd_n = 1'b0; ob_n = 8'd0;
    rd_addr = 16'(ocnt - COUNT_WIDTH'(offset));
    cmp_o_ge = 1'b0; cmp_i_ge = 1'b0; cmp_i_lt2 = 1'b0;
    oempty = 1'b0;

    if (in_word.mode == MODE_START) begin
      ph_n = PH_TOKEN; lit_n = '0; mat_n = '0; base_n = '0; off_n = '0; zf_n = 1'b0;
      oc_n = '0; ic_n = '0; st_n = ST_RUN; ok_n = 1'b0; raw_n = raw;
      if (ocap == 32'd0 || ulen > ocap) begin
        ph_n = PH_DONE; st_n = ST_CAP;
      end else if (clen > plen) begin
        ph_n = PH_DONE; st_n = ST_TRUNC;
      end
      for (int i = 0; i < 8; i++) begin
        if (ph_n != PH_DONE) begin
          if (raw_n) begin
            if (ulen == 32'd0) begin ph_n = PH_DONE; st_n = ST_FULL; ok_n = 1'b1; end
            else if (plen == 32'd0) begin ph_n = PH_DONE; st_n = ST_EXHAUST; ok_n = 1'b1; end
          end else if (ulen == 32'd0) begin ph_n = PH_DONE; st_n = ST_FULL; end
          else if (clen == 32'd0) begin ph_n = PH_DONE; st_n = ST_EXHAUST; end
        end
      end
    end else if (in_word.mode != MODE_IGNORE) begin
      for (int pass = 0; pass < 2; pass++) begin
        for (int i = 0; i < 4; i++) begin
          cmp_o_ge  = 64'(oc_n) >= 64'(ulen);
          cmp_i_ge  = 64'(ic_n) >= 64'(clen);
          cmp_i_lt2 = cmp_i_ge || (64'(clen) - 64'(ic_n)) < 64'd2;
          oempty = oc_n == '0;
          if (ph_n != PH_DONE) begin
            if (raw_n) begin
              if (cmp_o_ge) begin ph_n = PH_DONE; st_n = ST_FULL; ok_n = 1'b1; end
              else if (64'(ic_n) >= 64'(plen)) begin
                ph_n = PH_DONE; st_n = ST_EXHAUST; ok_n = 1'b1;
              end
            end else begin
              unique case (ph_n)
                PH_TOKEN: begin
                  if (cmp_o_ge) begin ph_n = PH_DONE; st_n = ST_FULL; ok_n = !oempty; end
                  else if (cmp_i_ge) begin
                    ph_n = PH_DONE; st_n = ST_EXHAUST; ok_n = !oempty;
                  end
                end
                PH_LITEXT: if (cmp_i_ge) ph_n = PH_LITERAL;
                PH_LITERAL: begin
                  if (!(lit_n != 0 && !cmp_i_ge && !cmp_o_ge)) begin
                    if (cmp_o_ge) begin ph_n = PH_DONE; st_n = ST_FULL; ok_n = !oempty; end
                    else if (base_n != 4'd0) begin
                      if (cmp_i_lt2) begin
                        ph_n = PH_DONE; st_n = ST_EXHAUST; ok_n = !oempty;
                      end else ph_n = PH_OFFLO;
                    end else ph_n = PH_TOKEN;
                  end
                end
                PH_OFFLO, PH_OFFHI: begin
                  if (cmp_i_ge) begin ph_n = PH_DONE; st_n = ST_EXHAUST; ok_n = !oempty; end
                end
                PH_MATCHEXT: begin
                  if (cmp_i_ge) begin
                    zf_n = COUNT_WIDTH'(off_n) > oc_n;
                    ph_n = PH_COPY;
                  end
                end
                PH_COPY: if (!(mat_n != 0 && !cmp_o_ge)) ph_n = PH_TOKEN;
                default: ;
              endcase
            end
          end
        end
        if (pass == 0) begin
          if (in_word.mode == MODE_FEED) begin
            if (ph_n != PH_DONE && ph_n != PH_COPY) begin
              acc_n = 1'b1;
              if (ic_n != CMAX) ic_n = ic_n + 1'b1;
              if (raw_n) begin
                ov_n = 1'b1; ob_n = in_word.data;
              end else begin
                unique case (ph_n)
                  PH_TOKEN: begin
                    base_n = in_word.data[3:0];
                    lit_n  = {28'd0, in_word.data[7:4]};
                    ph_n   = (in_word.data[7:4] == NIB_EXT) ? PH_LITEXT : PH_LITERAL;
                  end
                  PH_LITEXT: begin
                    lit_n = sat_add(lit_n, in_word.data);
                    if (in_word.data != BYTE_EXT) ph_n = PH_LITERAL;
                  end
                  PH_LITERAL: begin
                    ov_n = 1'b1; ob_n = in_word.data; lit_n = lit_n - 32'd1;
                  end
                  PH_OFFLO: begin
                    off_n = {8'd0, in_word.data}; ph_n = PH_OFFHI;
                  end
                  PH_OFFHI: begin
                    off_n = {in_word.data, off_n[7:0]};
                    if (off_n == 16'd0) begin
                      ph_n = PH_DONE; st_n = ST_ZOFF; ok_n = oc_n != '0;
                    end else begin
                      mat_n = {28'd0, base_n} + {27'd0, MATCH_MIN};
                      if (base_n == NIB_EXT) ph_n = PH_MATCHEXT;
                      else begin
                        zf_n = COUNT_WIDTH'(off_n) > oc_n;
                        ph_n = PH_COPY;
                      end
                    end
                  end
                  PH_MATCHEXT: begin
                    mat_n = sat_add(mat_n, in_word.data);
                    if (in_word.data != BYTE_EXT) begin
                      zf_n = COUNT_WIDTH'(off_n) > oc_n;
                      ph_n = PH_COPY;
                    end
                  end
                  default: ;
                endcase
              end
            end
          end else if (ph_n == PH_COPY) begin
            ov_n = 1'b1;
            rd_addr = 16'(oc_n - COUNT_WIDTH'(off_n));
            hist_n = !zf_n;
            fwd_n = !zf_n && off_n == 16'd1;
            mat_n = mat_n - 32'd1;
          end
          if (ov_n && oc_n != CMAX) oc_n = oc_n + 1'b1;
        end
      end
    end
  end

  // write address for the byte going out this cycle (known only in stage 2 for copies)
  logic [7:0]  s_final;
  logic [15:0] s_waddr;
  assign s_final = s_fwd ? last_byte : (s_hist ? s_rd : s_byte);

  logic take;
  assign take = in_take;

  always_ff @(posedge clk) begin
    if (take) begin
      s_rd <= history[rd_addr];
    end
    if (s_valid && adv_ok && s_ovalid) begin
      history[s_waddr] <= s_final;
    end
  end

  // forward when a copy reads the byte still in stage 2
  logic [15:0] s_waddr_n;
  assign s_waddr_n = 16'(ocnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TOKEN; lit_rem <= '0; match_rem <= '0; base <= '0; offset <= '0;
      zfill <= 1'b0; chunk_raw <= 1'b0; ok <= 1'b0; ocnt <= '0; icnt <= '0;
      status <= ST_RUN; s_valid <= 1'b0; r_valid <= 1'b0;
    end else begin
      if (r_valid && !o_stall) r_valid <= 1'b0;
      if (s_valid && adv_ok) begin
        r_valid <= 1'b1;
        s_valid <= 1'b0;
      end
      if (take) begin
        phase <= ph_n; lit_rem <= lit_n; match_rem <= mat_n; base <= base_n;
        offset <= off_n; zfill <= zf_n; chunk_raw <= raw_n; ok <= ok_n;
        ocnt <= oc_n; icnt <= ic_n; status <= st_n;
        s_valid <= 1'b1;
      end
    end
  end

  // match forwarding: offset one from the byte in stage 2, or the true read otherwise
  logic fwd_live;
  assign fwd_live = s_valid && s_ovalid && rd_addr == s_waddr;

  always_ff @(posedge clk) begin
    if (take) begin
      s_accepted <= acc_n; s_ovalid <= ov_n; s_byte <= ob_n;
      s_hist <= hist_n; s_fwd <= hist_n && (fwd_live || fwd_n && s_valid && s_ovalid
                                            && rd_addr == s_waddr);
      s_phase <= ph_n; s_status <= st_n; s_ok <= ok_n;
      s_ocnt <= 32'(oc_n); s_icnt <= 32'(ic_n);
      s_waddr <= s_waddr_n;
      if (s_valid && s_ovalid) last_byte <= s_final;
    end
    if (s_valid && adv_ok) begin
      accepted <= s_accepted; out_valid <= s_ovalid;
      out_byte <= s_ovalid ? s_final : 8'd0;
      copy_pending <= s_phase == PH_COPY; finished <= s_phase == PH_DONE;
      end_status <= s_status; success <= s_phase == PH_DONE && s_ok;
      bytes_written <= s_ocnt; bytes_consumed <= s_icnt;
    end
  end

  assign o_valid = r_valid;
endmodule

### src/lz77_token_stream_decoder.sv
// LZ4-style token stream decoder. Words pass through a two-entry queue into the
// decode core, which takes one word a cycle unless its stage and output register
// are both full while the output stalls, issues the 64 KiB history read at that
// edge and resolves the output byte in the following stage (a byte still in that
// stage is forwarded, which covers offset one), then holds the result word in an
// output register. Every word gives one result word and words can follow with no
// gap; up to four words are held inside while the output stalls. Config writes
// take effect at once and belong between chunks.
module lz77_token_stream_decoder
  import lzd_pkg::*;
#(
  parameter int COUNT_WIDTH   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  in_byte,
  output logic        out_valid_w,
  input  logic        out_stall,
  output logic        accepted,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        copy_pending,
  output logic        finished,
  output logic [2:0]  end_status,
  output logic        success,
  output logic [31:0] bytes_written,
  output logic [31:0] bytes_consumed
);
  logic [31:0] ulen, clen, plen, ocap;
  logic        raw;
  word_t       q_word;
  logic        q_valid, q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      ulen <= '0; clen <= '0; plen <= '0; ocap <= '0; raw <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ULEN: ulen <= cfg_data;
        REG_CLEN: clen <= cfg_data;
        REG_PLEN: plen <= cfg_data;
        REG_OCAP: ocap <= cfg_data;
        REG_RAW:  raw  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lzd_queue u_queue (
    .clk, .rst,
    .wr_valid(in_valid), .wr_stall(in_stall), .wr_word('{mode: mode, data: in_byte}),
    .rd_valid(q_valid), .rd_take(q_take), .rd_word(q_word)
  );

  lzd_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
    .clk, .rst,
    .in_valid(q_valid), .in_take(q_take), .in_word(q_word),
    .ulen, .clen, .plen, .ocap, .raw,
    .o_valid(out_valid_w), .o_stall(out_stall),
    .accepted, .out_valid, .out_byte, .copy_pending, .finished,
    .end_status, .success, .bytes_written, .bytes_consumed
  );

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid_w && end_status != ST_RUN |-> finished)
    else $error("status without finish");
  a_copy: assert property (@(posedge clk) disable iff (rst)
    out_valid_w |-> !(copy_pending && finished))
    else $error("copy and finish together");
  a_acc: assert property (@(posedge clk) disable iff (rst)
    out_valid_w && out_valid && !copy_pending |-> bytes_written != 32'd0)
    else $error("byte without count");
endmodule

### bench/tb_lz77_token_stream_decoder.sv
module tb_lz77_token_stream_decoder;
  import lzd_pkg::*;

  localparam int LIMIT = 400000;

  typedef struct packed {
    logic        accepted;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        copy_pending;
    logic        finished;
    logic [2:0]  end_status;
    logic        success;
    logic [31:0] bytes_written;
    logic [31:0] bytes_consumed;
  } result_t;

  typedef struct {
    logic [1:0] mode;
    logic [7:0] data;
    logic       has_known;
    result_t    known;
  } row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  mode = MODE_FEED;
  logic [7:0]  in_byte = '0;
  logic        out_valid_w;
  logic        out_stall = 0;
  logic        accepted, out_valid, copy_pending, finished, success;
  logic [7:0]  out_byte;
  logic [2:0]  end_status;
  logic [31:0] bytes_written, bytes_consumed;

  lz77_token_stream_decoder i_dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // decoder copy of the block state
  logic [31:0] r_ulen, r_clen, r_plen, r_ocap;
  logic        r_raw;
  logic [7:0]  hist [0:65535];
  phase_t      ph;
  logic [31:0] lit_left, match_left, out_cnt, in_cnt;
  logic [3:0]  base_nib;
  logic [15:0] offs;
  logic        zfill, raw_chunk, ok;
  logic [2:0]  status;

  result_t expected_q [$];
  row_t    rows [$];
  int      errors = 0;
  int      cycles = 0;
  bit      long_hold = 0;
  bit      held = 0;

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [7:0] b);
    logic [32:0] s;
    s = {1'b0, a} + b;
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void inc_sat(ref logic [31:0] c);
    if (c != 32'hFFFF_FFFF) c++;
  endfunction

  function automatic void end_chunk(logic [2:0] code, logic good);
    ph = PH_DONE;
    status = code;
    ok = good;
  endfunction

  function automatic void store_byte(logic [7:0] b);
    hist[out_cnt[15:0]] = b;
    inc_sat(out_cnt);
  endfunction

  function automatic void start_copy();
    zfill = offs > out_cnt;
    ph = PH_COPY;
  endfunction

  function automatic void settle();
    for (int i = 0; i < 8; i++) begin
      if (ph == PH_DONE) return;
      if (raw_chunk) begin
        if (out_cnt >= r_ulen) end_chunk(ST_FULL, 1);
        else if (in_cnt >= r_plen) end_chunk(ST_EXHAUST, 1);
        return;
      end
      case (ph)
        PH_TOKEN: begin
          if (out_cnt >= r_ulen) end_chunk(ST_FULL, out_cnt > 0);
          else if (in_cnt >= r_clen) end_chunk(ST_EXHAUST, out_cnt > 0);
          return;
        end
        PH_LITEXT: begin
          if (in_cnt < r_clen) return;
          ph = PH_LITERAL;
        end
        PH_LITERAL: begin
          if (lit_left != 0 && in_cnt < r_clen && out_cnt < r_ulen) return;
          if (out_cnt >= r_ulen) end_chunk(ST_FULL, out_cnt > 0);
          else if (base_nib > 0) begin
            if (in_cnt >= r_clen || r_clen - in_cnt < 2) end_chunk(ST_EXHAUST, out_cnt > 0);
            else ph = PH_OFFLO;
          end else ph = PH_TOKEN;
        end
        PH_OFFLO, PH_OFFHI: begin
          if (in_cnt >= r_clen) end_chunk(ST_EXHAUST, out_cnt > 0);
          return;
        end
        PH_MATCHEXT: begin
          if (in_cnt < r_clen) return;
          start_copy();
        end
        default: begin
          if (match_left != 0 && out_cnt < r_ulen) return;
          ph = PH_TOKEN;
        end
      endcase
    end
  endfunction

  function automatic void clear_decoder();
    ph = PH_TOKEN;
    lit_left = 0; match_left = 0; base_nib = 0; offs = 0; zfill = 0;
    out_cnt = 0; in_cnt = 0; status = ST_RUN; ok = 0;
  endfunction

  function automatic result_t decode_word(logic [1:0] m, logic [7:0] b);
    result_t r;
    r = '0;
    if (m == MODE_START) begin
      clear_decoder();
      raw_chunk = r_raw;
      if (r_ocap == 0 || r_ulen > r_ocap) end_chunk(ST_CAP, 0);
      else if (r_clen > r_plen) end_chunk(ST_TRUNC, 0);
      settle();
    end else if (m != MODE_IGNORE) begin
      settle();
      if (m == MODE_FEED) begin
        if (ph != PH_DONE && ph != PH_COPY) begin
          r.accepted = 1;
          inc_sat(in_cnt);
          if (raw_chunk) begin
            store_byte(b); r.out_valid = 1; r.out_byte = b;
          end else case (ph)
            PH_TOKEN: begin
              base_nib = b[3:0];
              lit_left = {28'd0, b[7:4]};
              ph = (b[7:4] == NIB_EXT) ? PH_LITEXT : PH_LITERAL;
            end
            PH_LITEXT: begin
              lit_left = add_sat(lit_left, b);
              if (b != BYTE_EXT) ph = PH_LITERAL;
            end
            PH_LITERAL: begin
              store_byte(b); r.out_valid = 1; r.out_byte = b;
              lit_left--;
            end
            PH_OFFLO: begin
              offs = {8'h00, b};
              ph = PH_OFFHI;
            end
            PH_OFFHI: begin
              offs[15:8] = b;
              if (offs == 0) end_chunk(ST_ZOFF, out_cnt > 0);
              else begin
                match_left = 32'(base_nib) + 32'(MATCH_MIN);
                if (base_nib == NIB_EXT) ph = PH_MATCHEXT;
                else start_copy();
              end
            end
            default: begin
              match_left = add_sat(match_left, b);
              if (b != BYTE_EXT) start_copy();
            end
          endcase
        end
      end else if (ph == PH_COPY) begin
        r.out_byte = zfill ? 8'h00 : hist[out_cnt[15:0] - offs];
        store_byte(r.out_byte);
        r.out_valid = 1;
        match_left--;
      end
      settle();
    end
    r.copy_pending = ph == PH_COPY;
    r.finished = ph == PH_DONE;
    r.end_status = status;
    r.success = ph == PH_DONE && ok;
    r.bytes_written = out_cnt;
    r.bytes_consumed = in_cnt;
    return r;
  endfunction

  function automatic void add_row(logic [1:0] m, logic [7:0] b);
    row_t w;
    w.mode = m; w.data = b; w.has_known = 0; w.known = '0;
    rows.push_back(w);
  endfunction

  function automatic void add_known(logic [1:0] m, logic [2:0] st, logic good);
    row_t w;
    w.mode = m; w.data = 8'h00; w.has_known = 1;
    w.known = '0;
    w.known.finished = 1; w.known.end_status = st; w.known.success = good;
    rows.push_back(w);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_ULEN: r_ulen = val;
      REG_CLEN: r_clen = val;
      REG_PLEN: r_plen = val;
      REG_OCAP: r_ocap = val;
      default:  r_raw = val[0];
    endcase
  endtask

  task automatic set_chunk(logic [31:0] ul, logic [31:0] cl, logic [31:0] pl,
                           logic [31:0] oc, logic rw);
    write_reg(REG_ULEN, ul);
    write_reg(REG_CLEN, cl);
    write_reg(REG_PLEN, pl);
    write_reg(REG_OCAP, oc);
    write_reg(REG_RAW, {31'b0, rw});
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // send every queued row, predicting as each is accepted
  task automatic send_rows(bit bursty);
    row_t    w;
    result_t e;
    int      burst;
    burst = $urandom_range(1, 20);
    while (rows.size() != 0) begin
      w = rows.pop_front();
      if (bursty && burst == 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst = $urandom_range(1, 20);
      end
      in_valid <= 1; mode <= w.mode; in_byte <= w.data;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      e = decode_word(w.mode, w.data);
      if (w.has_known && (w.known.finished != e.finished ||
          w.known.end_status != e.end_status || w.known.success != e.success))
        $display("%0t note: predictor disagrees with table row", $time);
      if (w.has_known) begin
        w.known.bytes_written = e.bytes_written;
        w.known.bytes_consumed = e.bytes_consumed;
        w.known.copy_pending = e.copy_pending;
        expected_q.push_back(w.known);
      end else expected_q.push_back(e);
      if (burst > 0) burst--;
    end
    in_valid <= 0;
  endtask

  // a well-formed token: literals, then an optional match with a nonzero offset
  function automatic void add_token(int max_lit, int written);
    int lit, nib, off;
    lit = $urandom_range(0, max_lit);
    nib = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
    if (written + lit == 0) nib = 0;
    if (lit >= 15) begin
      add_row(MODE_FEED, {4'hF, nib[3:0]});
      add_row(MODE_FEED, 8'(lit - 15));
    end else add_row(MODE_FEED, {lit[3:0], nib[3:0]});
    for (int i = 0; i < lit; i++) add_row(MODE_FEED, 8'($urandom));
    if (nib != 0) begin
      off = $urandom_range(0, 7) == 0 ? $urandom_range(1, 65535)
                                      : $urandom_range(1, written + lit);
      add_row(MODE_FEED, off[7:0]);
      add_row(MODE_FEED, off[15:8]);
      if (nib == 15) add_row(MODE_FEED, 8'($urandom_range(0, 6)));
      for (int i = 0; i < 28; i++) add_row(MODE_TICK, 8'($urandom));
    end
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (long_hold) out_stall <= 1;
    else case ((cycles / 64) % 3)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  always @(posedge clk) begin
    result_t a, e;
    if (!rst && out_valid_w && !out_stall) begin
      a = {accepted, out_valid, out_byte, copy_pending, finished, end_status,
           success, bytes_written, bytes_consumed};
      if (expected_q.size() == 0) begin
        $display("%0t unexpected word %h", $time, a);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (a !== e) begin
          $display("%0t mismatch: expected %h actual %h", $time, e, a);
          errors++;
        end
      end
    end
  end

  initial begin
    int n, sent;
    for (int i = 0; i < 65536; i++) hist[i] = 0;
    r_ulen = 0; r_clen = 0; r_plen = 0; r_ocap = 0; r_raw = 0;
    raw_chunk = 0;
    clear_decoder();
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // before any start: zero lengths finish at once
    add_row(MODE_FEED, 8'h00);
    add_row(MODE_IGNORE, 8'hFF);
    add_known(MODE_START, ST_CAP, 0);
    send_rows(0);
    drain();

    set_chunk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 0);
    add_known(MODE_START, ST_TRUNC, 0);
    send_rows(0);
    drain();

    // overlapping copy, far offset, zero offset
    set_chunk(40, 20, 20, 32'hFFFF_FFFF, 0);
    add_row(MODE_START, 0);
    add_row(MODE_FEED, 8'h11); add_row(MODE_FEED, 8'hA5);
    add_row(MODE_FEED, 8'h01); add_row(MODE_FEED, 8'h00);
    add_row(MODE_FEED, 8'h77);
    for (int i = 0; i < 5; i++) add_row(MODE_TICK, 0);
    add_row(MODE_TICK, 0);
    add_row(MODE_FEED, 8'h01); add_row(MODE_FEED, 8'hFF); add_row(MODE_FEED, 8'hFF);
    for (int i = 0; i < 5; i++) add_row(MODE_TICK, 0);
    add_row(MODE_FEED, 8'h0F);
    add_row(MODE_FEED, 8'h00); add_row(MODE_FEED, 8'h00);
    send_rows(0);
    drain();

    // extended literal, then the input runs out before the offset
    set_chunk(100, 20, 30, 100, 0);
    add_row(MODE_START, 0);
    add_row(MODE_FEED, 8'hF3); add_row(MODE_FEED, 8'h02);
    for (int i = 0; i < 17; i++) add_row(MODE_FEED, 8'($urandom));
    add_row(MODE_FEED, 8'h01);
    add_row(MODE_FEED, 8'h55);
    send_rows(0);
    drain();

    // raw mode
    set_chunk(6, 4, 8, 6, 1);
    add_row(MODE_START, 0);
    for (int i = 0; i < 8; i++) add_row(MODE_FEED, 8'($urandom));
    send_rows(0);
    drain();

    // random chunks
    sent = 0;
    while (sent < 380) begin
      int written, clen;
      bit rw;
      rw = $urandom_range(0, 5) == 0;
      if (rw) begin
        n = $urandom_range(0, 20);
        set_chunk($urandom_range(0, 24), $urandom_range(0, 20), n, 64, 1);
        add_row(MODE_START, 0);
        for (int i = 0; i < n + 2; i++) add_row(MODE_FEED, 8'($urandom));
      end else if ($urandom_range(0, 9) == 0) begin
        set_chunk($urandom_range(0, 40), $urandom_range(0, 40),
                  $urandom_range(0, 40), $urandom_range(0, 40), 0);
        add_row(MODE_START, 0);
        for (int i = 0; i < 30; i++) add_row(2'($urandom_range(0, 3)), 8'($urandom));
      end else begin
        add_row(MODE_FEED, 0);
        rows.delete();
        written = 0;
        for (int t = 0; t < $urandom_range(1, 4); t++) begin
          int row_start;
          row_start = rows.size();
          add_token(20, written);
          for (int i = row_start; i < rows.size(); i++)
            if (rows[i].mode == MODE_TICK) written++;
          written += 20;
        end
        clen = 0;
        foreach (rows[i]) if (rows[i].mode == MODE_FEED) clen++;
        if ($urandom_range(0, 4) == 0) clen = $urandom_range(0, clen);
        rows.push_front('{MODE_START, 8'h00, 1'b0, '0});
        set_chunk($urandom_range(0, 2) == 0 ? $urandom_range(1, 30) : 32'd1000,
                  clen, clen + $urandom_range(0, 3), 32'd1000, 0);
        // non-raw chunk: history reads may fall outside the written range
      end
      sent += rows.size();
      if (sent > 150 && !held) begin
        held = 1;
        fork
          begin
            long_hold = 1;
            repeat (200) @(posedge clk);
            long_hold = 0;
          end
        join_none
      end
      send_rows(1);
      if ($urandom_range(0, 3) == 0) drain();
      else begin
        while (expected_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
src/lzd_pkg.sv
src/lzd_queue.sv
src/lzd_core.sv
src/lz77_token_stream_decoder.sv
bench/tb_lz77_token_stream_decoder.sv
